### design/vcgs_pkg.sv
// Shared constants and types for the vector chain smoother.
`default_nettype none

package vcgs_pkg;

    // Filter geometry: eleven taps, five on each side of the center.
    localparam int TAPS = 11;
    localparam int HALF_TAPS = 5;

    // One lane per vector component.
    localparam int LANES = 3;

    // Weights of the symmetric tap pairs, outermost pair first, and of the center tap.
    localparam int PAIR_WEIGHT [HALF_TAPS] = '{1, 2, 4, 7, 9};
    localparam int CENTER_WEIGHT = 10;

    // Rounding and the division by 56, done as a shift by 3 and a division by 7.
    localparam int ROUND_BIAS = 28;
    localparam int DIV_SHIFT = 3;
    localparam int DIV_ODD = 7;

    // Per-cycle control that a pass hands to each of its component lanes.
    typedef struct packed {
        logic push;
        logic load_all;
        logic use_pad;
        logic en1;
        logic en2;
        logic en3;
    } vcgs_lane_ctrl_t;

endpackage

`default_nettype wire

### design/vector_chain_gaussian_smoother.sv
// Top level of the vector chain smoother: a cascade of smoothing passes.
//
// Input channel (in_valid/in_ready) takes one chain vector per item, with
// chain_end set on the chain's final vector. Output channel
// (out_valid/out_ready) gives one smoothed vector per item, out_last set on
// the final result of a chain. Each pass is an 11-tap filter, weights
// 1,2,4,7,9,10,9,7,4,2,1, rounded and divided by 56, with the chain ends
// repeated as neighbors; PASS_COUNT passes run in cascade.
// Throughput: one item per cycle inside a chain while no back-pressure holds
// it. After an item with chain_end the first pass pushes its last value 5
// more times, and input is held off while it does; that flush sets the
// per-chain cost. Each pass holds back 5 items and adds 3 register stages,
// so with PASS_COUNT = 5 input k releases result k-25. Reset empties
// every pass; no result is pending.
// When the receiver stalls, results wait in the pass registers and the
// stall backs up the cascade until the input channel drops in_ready.
`default_nettype none

module vector_chain_gaussian_smoother #(
    parameter int PASS_COUNT     = 5,
    parameter int COMPONENT_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [COMPONENT_BITS-1:0] vec_x,
    input  logic signed [COMPONENT_BITS-1:0] vec_y,
    input  logic signed [COMPONENT_BITS-1:0] vec_z,
    input  logic                            chain_end,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [COMPONENT_BITS-1:0] smooth_x,
    output logic signed [COMPONENT_BITS-1:0] smooth_y,
    output logic signed [COMPONENT_BITS-1:0] smooth_z,
    output logic                            out_last
);
    import vcgs_pkg::*;

    logic                             st_valid [PASS_COUNT+1];
    logic                             st_ready [PASS_COUNT+1];
    logic                             st_last  [PASS_COUNT+1];
    logic signed [COMPONENT_BITS-1:0] st_comp  [PASS_COUNT+1][LANES];

    // Cascade entry.
    assign st_valid[0]   = in_valid;
    assign in_ready      = st_ready[0];
    assign st_comp[0][0] = vec_x;
    assign st_comp[0][1] = vec_y;
    assign st_comp[0][2] = vec_z;
    assign st_last[0]    = chain_end;

    // Each pass reads only what the pass before it produced.
    for (genvar p = 0; p < PASS_COUNT; p++)
    begin : g_pass
        vcgs_pass #(
            .W(COMPONENT_BITS)
        ) u_pass (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[p]),
            .in_ready  (st_ready[p]),
            .in_comp   (st_comp[p]),
            .in_last   (st_last[p]),
            .out_valid (st_valid[p+1]),
            .out_ready (st_ready[p+1]),
            .out_comp  (st_comp[p+1]),
            .out_last  (st_last[p+1])
        );
    end

    // Cascade exit.
    assign st_ready[PASS_COUNT] = out_ready;
    assign out_valid = st_valid[PASS_COUNT];
    assign smooth_x  = st_comp[PASS_COUNT][0];
    assign smooth_y  = st_comp[PASS_COUNT][1];
    assign smooth_z  = st_comp[PASS_COUNT][2];
    assign out_last  = st_last[PASS_COUNT];

endmodule

`default_nettype wire

### design/vcgs_lane.sv
// One component lane of a smoothing pass: tap window, weighted sum and division by 56.
`default_nettype none

module vcgs_lane #(
    parameter int W = 16
) (
    input  logic                      clk,
    input  vcgs_pkg::vcgs_lane_ctrl_t ctrl,
    input  logic signed [W-1:0]       in_val,
    output logic signed [W-1:0]       out_val
);
    import vcgs_pkg::*;

    localparam int PW = W + 1;
    localparam int AW = W + 6;
    localparam int UW = W + 4;
    localparam logic [UW-1:0] RECIP = UW'((64'd1 << UW) / 64'(DIV_ODD));
    localparam logic signed [AW-1:0] BIAS = AW'(64'(DIV_ODD) << W);

    logic signed [W-1:0]  tap_reg [TAPS];
    logic signed [W-1:0]  tap_next [TAPS];
    logic signed [W-1:0]  push_val;
    logic signed [PW-1:0] pair_reg [HALF_TAPS];
    logic signed [PW-1:0] pair_next [HALF_TAPS];
    logic signed [W-1:0]  ctr_reg;
    logic signed [W-1:0]  ctr_next;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] acc_next;
    logic signed [AW-1:0] shifted;
    logic signed [AW-1:0] biased;
    logic [UW-1:0]        quot_in;
    logic [2*UW-1:0]      prod;
    logic [UW-1:0]        est;
    logic [UW-1:0]        rem;
    logic [UW-1:0]        quot;
    logic signed [W-1:0]  out_reg;
    logic signed [W-1:0]  out_next;

    // Window update: the first value of a chain fills every tap, later values shift in.
    always_comb
    begin
        push_val = ctrl.use_pad ? tap_reg[TAPS-1] : in_val;
        for (int i = 0; i < TAPS; i++)
        begin
            tap_next[i] = tap_reg[i];
        end
        if (ctrl.push)
        begin
            if (ctrl.load_all)
            begin
                for (int i = 0; i < TAPS; i++)
                begin
                    tap_next[i] = push_val;
                end
            end
            else
            begin
                for (int i = 0; i < TAPS - 1; i++)
                begin
                    tap_next[i] = tap_reg[i+1];
                end
                tap_next[TAPS-1] = push_val;
            end
        end
    end

    // First stage: fold the symmetric taps into pair sums.
    always_comb
    begin
        for (int i = 0; i < HALF_TAPS; i++)
        begin
            pair_next[i] = PW'(tap_next[i]) + PW'(tap_next[TAPS-1-i]);
        end
        ctr_next = tap_next[HALF_TAPS];
    end

    // Second stage: weighted sum of the pairs and the center, plus the rounding bias.
    always_comb
    begin
        acc_next = AW'(ROUND_BIAS) + AW'(CENTER_WEIGHT) * AW'(ctr_reg);
        for (int i = 0; i < HALF_TAPS; i++)
        begin
            acc_next = acc_next + AW'(PAIR_WEIGHT[i]) * AW'(pair_reg[i]);
        end
    end

    // Third stage: floor by 8 with a shift, then floor by 7 on a biased, non-negative value.
    // The reciprocal estimate is low by at most one, so a single correction suffices.
    always_comb
    begin
        shifted  = acc_reg >>> DIV_SHIFT;
        biased   = shifted + BIAS;
        quot_in  = biased[UW-1:0];
        prod     = (2*UW)'(quot_in) * (2*UW)'(RECIP);
        est      = prod[2*UW-1:UW];
        rem      = quot_in - est * UW'(DIV_ODD);
        quot     = (rem >= UW'(DIV_ODD)) ? est + UW'(1) : est;
        out_next = quot[W-1:0];
    end

    // Payload registers; validity is tracked by the pass control.
    always_ff @(posedge clk)
    begin
        tap_reg <= tap_next;
        if (ctrl.en1)
        begin
            pair_reg <= pair_next;
            ctr_reg  <= ctr_next;
        end
        if (ctrl.en2)
        begin
            acc_reg <= acc_next;
        end
        if (ctrl.en3)
        begin
            out_reg <= out_next;
        end
    end

    assign out_val = out_reg;

endmodule

`default_nettype wire

### design/vcgs_pass.sv
// One smoothing pass: fill and padding control, three component lanes and merged output.
`default_nettype none

module vcgs_pass #(
    parameter int W = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [W-1:0] in_comp [vcgs_pkg::LANES],
    input  logic               in_last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [W-1:0] out_comp [vcgs_pkg::LANES],
    output logic               out_last
);
    import vcgs_pkg::*;

    localparam int FW = $clog2(TAPS + 1);
    localparam int KW = $clog2(HALF_TAPS + 1);

    logic [FW-1:0]   fill_reg;
    logic [FW-1:0]   fill_next;
    logic [FW-1:0]   fill_after;
    logic [KW-1:0]   pad_left_reg;
    logic [KW-1:0]   pad_left_next;
    logic            v1_reg, v2_reg, v3_reg;
    logic            v1_next, v2_next, v3_next;
    logic            l1_reg, l2_reg, l3_reg;
    logic            en1, en2, en3;
    logic            padding;
    logic            in_push;
    logic            pad_push;
    logic            push;
    logic            emit;
    logic            last_emit;
    vcgs_lane_ctrl_t lane_ctrl;

    // Elastic stage enables, from the output back toward the window.
    assign en3 = !v3_reg || out_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    // After a chain's last item the pass repeats its last value to flush the window.
    assign padding  = (pad_left_reg != '0);
    assign in_ready = !padding && en1;
    assign in_push  = in_valid && in_ready;
    assign pad_push = padding && en1;
    assign push     = in_push || pad_push;

    // Fill level after a push; a full window produces one result.
    always_comb
    begin
        if (fill_reg == '0)
        begin
            fill_after = FW'(HALF_TAPS + 1);
        end
        else if (fill_reg == FW'(TAPS))
        begin
            fill_after = FW'(TAPS);
        end
        else
        begin
            fill_after = fill_reg + FW'(1);
        end
    end

    assign emit      = push && (fill_after == FW'(TAPS));
    assign last_emit = pad_push && (pad_left_reg == KW'(1));

    // Next state of the fill and padding counters and the stage valid bits.
    always_comb
    begin
        fill_next     = fill_reg;
        pad_left_next = pad_left_reg;
        if (last_emit)
        begin
            fill_next = '0;
        end
        else if (push)
        begin
            fill_next = fill_after;
        end
        if (in_push && in_last)
        begin
            pad_left_next = KW'(HALF_TAPS);
        end
        else if (pad_push)
        begin
            pad_left_next = pad_left_reg - KW'(1);
        end
        v1_next = en1 ? emit : v1_reg;
        v2_next = en2 ? v1_reg : v2_reg;
        v3_next = en3 ? v2_reg : v3_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            pad_left_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            pad_left_reg <= pad_left_next;
            v1_reg       <= v1_next;
            v2_reg       <= v2_next;
            v3_reg       <= v3_next;
        end
    end

    // The last-of-chain mark travels beside the lane pipeline.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            l1_reg <= last_emit;
        end
        if (en2)
        begin
            l2_reg <= l1_reg;
        end
        if (en3)
        begin
            l3_reg <= l2_reg;
        end
    end

    // Control shared by all component lanes.
    assign lane_ctrl.push     = push;
    assign lane_ctrl.load_all = (fill_reg == '0);
    assign lane_ctrl.use_pad  = padding;
    assign lane_ctrl.en1      = en1;
    assign lane_ctrl.en2      = en2;
    assign lane_ctrl.en3      = en3;

    // Component lanes working side by side.
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        vcgs_lane #(
            .W(W)
        ) u_lane (
            .clk     (clk),
            .ctrl    (lane_ctrl),
            .in_val  (in_comp[g]),
            .out_val (out_comp[g])
        );
    end

    // Merged result: lane values together with the shared valid and last mark.
    assign out_valid = v3_reg;
    assign out_last  = l3_reg;

    // The window never reports more than its tap count.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(TAPS))
        else $error("fill level above tap count");

    // The final padding push always completes a full window.
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        last_emit |-> emit)
        else $error("final padding push produced no result");

    // A flush leaves the pass empty and ready for the next chain.
    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        last_emit |=> (fill_reg == '0) && !padding)
        else $error("pass not empty after flush");

    // Padding only happens on a window that holds data.
    a_pad_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        padding |-> (fill_reg != '0))
        else $error("padding an empty window");

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
// Testbench for the vector chain smoother: random chains checked against a cascaded-pass predictor.

module testbench;

    import vcgs_pkg::*;

    localparam int PASS_COUNT     = 5;
    localparam int COMPONENT_BITS = 16;
    localparam int MAX_RESULTS    = 1 + HALF_TAPS * PASS_COUNT;
    localparam int DIVISOR        = (1 << DIV_SHIFT) * DIV_ODD;
    localparam int DRAIN_CYCLES   = 8 * PASS_COUNT + 20;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TOTAL_ITEMS    = 260;

    // One smoothed vector as it leaves the block.
    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] x;
        logic signed [COMPONENT_BITS-1:0] y;
        logic signed [COMPONENT_BITS-1:0] z;
        logic                             last;
    } smooth_vec_t;

    // Three wide components that a pass works on.
    typedef logic [2:0][31:0] triple_t;

    // Scoreboard: runs every accepted vector through the passes and checks the results.
    class smoother_scoreboard;
        triple_t     taps [PASS_COUNT][TAPS];
        int          fill [PASS_COUNT];
        triple_t     pass_out [$];
        smooth_vec_t expected_smooth [$];
        int          mismatches;
        int          checked;

        function new();
            for (int s = 0; s < PASS_COUNT; s++)
            begin
                fill[s] = 0;
                for (int i = 0; i < TAPS; i++)
                    taps[s][i] = '0;
            end
            mismatches = 0;
            checked = 0;
        endfunction

        function int pending();
            return expected_smooth.size();
        endfunction

        function int tap_weight(int i);
            if (i < HALF_TAPS)
                return PAIR_WEIGHT[i];
            else if (i == HALF_TAPS)
                return CENTER_WEIGHT;
            else
                return PAIR_WEIGHT[TAPS - 1 - i];
        endfunction

        // Rounds toward minus infinity.
        function int floor_div(int t);
            if (t >= 0)
                return t / DIVISOR;
            return -((-t + DIVISOR - 1) / DIVISOR);
        endfunction

        // Shifts one vector into pass s; a full window yields one filtered vector.
        function void shift_into_pass(int s, triple_t v);
            triple_t r;
            int      acc;
            if (fill[s] == 0)
            begin
                // The first element of a pass also stands for its left neighbors.
                for (int i = 0; i < TAPS; i++)
                    taps[s][i] = v;
                fill[s] = HALF_TAPS + 1;
            end
            else
            begin
                for (int i = 0; i < TAPS - 1; i++)
                    taps[s][i] = taps[s][i + 1];
                taps[s][TAPS - 1] = v;
                if (fill[s] < TAPS)
                    fill[s]++;
            end
            if (fill[s] == TAPS && pass_out.size() < MAX_RESULTS)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    acc = 0;
                    for (int i = 0; i < TAPS; i++)
                        acc += tap_weight(i) * $signed(taps[s][i][c]);
                    r[c] = floor_div(acc + ROUND_BIAS);
                end
                pass_out.insert(pass_out.size(), r);
            end
        endfunction

        // Notes an accepted input vector and queues the results it releases.
        function void note_input(logic signed [COMPONENT_BITS-1:0] x,
                                 logic signed [COMPONENT_BITS-1:0] y,
                                 logic signed [COMPONENT_BITS-1:0] z,
                                 logic end_mark);
            triple_t     stream [$];
            triple_t     v;
            triple_t     pad;
            smooth_vec_t res;
            v[0] = 32'(x);
            v[1] = 32'(y);
            v[2] = 32'(z);
            stream.insert(stream.size(), v);
            for (int s = 0; s < PASS_COUNT; s++)
            begin
                pass_out.delete();
                foreach (stream[k])
                    shift_into_pass(s, stream[k]);
                // At the chain end the last value of the pass is repeated to the right.
                if (end_mark)
                begin
                    pad = taps[s][TAPS - 1];
                    for (int p = 0; p < HALF_TAPS; p++)
                        shift_into_pass(s, pad);
                end
                stream = pass_out;
            end
            foreach (stream[k])
            begin
                res.x = stream[k][0][COMPONENT_BITS-1:0];
                res.y = stream[k][1][COMPONENT_BITS-1:0];
                res.z = stream[k][2][COMPONENT_BITS-1:0];
                res.last = end_mark && (k == stream.size() - 1);
                expected_smooth.insert(expected_smooth.size(), res);
            end
            if (end_mark)
                for (int s = 0; s < PASS_COUNT; s++)
                    fill[s] = 0;
        endfunction

        // Compares one accepted result with the oldest expected one.
        function void check_result(smooth_vec_t got);
            smooth_vec_t want;
            if (expected_smooth.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: x=%0d y=%0d z=%0d last=%0b",
                             got.x, got.y, got.z, got.last);
                return;
            end
            want = expected_smooth.pop_front();
            checked++;
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z
                || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch on result %0d: expected x=%0d y=%0d z=%0d last=%0b,",
                             checked - 1, want.x, want.y, want.z, want.last);
                    $display("    got x=%0d y=%0d z=%0d last=%0b",
                             got.x, got.y, got.z, got.last);
                end
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic signed [COMPONENT_BITS-1:0] vec_x;
    logic signed [COMPONENT_BITS-1:0] vec_y;
    logic signed [COMPONENT_BITS-1:0] vec_z;
    logic                             chain_end;
    logic                             out_valid;
    logic                             out_ready;
    logic signed [COMPONENT_BITS-1:0] smooth_x;
    logic signed [COMPONENT_BITS-1:0] smooth_y;
    logic signed [COMPONENT_BITS-1:0] smooth_z;
    logic                             out_last;

    smoother_scoreboard sb;
    logic quiet_mode;
    logic hold_request;
    logic hold_off;
    int   items_sent;
    int   chains_sent;
    int   cycles;

    vector_chain_gaussian_smoother #(
        .PASS_COUNT     (PASS_COUNT),
        .COMPONENT_BITS (COMPONENT_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .chain_end (chain_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .smooth_x  (smooth_x),
        .smooth_y  (smooth_y),
        .smooth_z  (smooth_z),
        .out_last  (out_last)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Idle length for either side: mostly short, now and then long.
    function automatic int pick_gap();
        int r;
        if (quiet_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Component value: extremes, values near zero, or anything.
    function automatic logic [COMPONENT_BITS-1:0] pick_component();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // Offers one item after a random gap and waits until it is taken.
    task automatic send_vec(input logic [COMPONENT_BITS-1:0] x,
                            input logic [COMPONENT_BITS-1:0] y,
                            input logic [COMPONENT_BITS-1:0] z,
                            input logic end_mark);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        vec_x     <= x;
        vec_y     <= y;
        vec_z     <= z;
        chain_end <= end_mark;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(x, y, z, end_mark);
        items_sent++;
        if (end_mark)
            chains_sent++;
    endtask

    // Sends a chain of random vectors; the last one carries the end mark.
    task automatic send_chain(input int len);
        for (int i = 0; i < len; i++)
            send_vec(pick_component(), pick_component(), pick_component(), i == len - 1);
    endtask

    // Timeout guard.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Long receiver hold-off while the sender keeps offering items.
    initial
    begin
        hold_off = 1'b0;
        @(posedge clk);
        while (!hold_request)
            @(posedge clk);
        hold_off <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++)
            @(posedge clk);
        hold_off <= 1'b0;
    end

    // Receiver: checks each accepted result and stalls at random.
    initial
    begin
        int stall_left;
        smooth_vec_t got;
        stall_left = 0;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.x = smooth_x;
                got.y = smooth_y;
                got.z = smooth_z;
                got.last = out_last;
                sb.check_result(got);
            end
            if (stall_left > 0)
                stall_left--;
            else
                stall_left = pick_gap();
            out_ready <= !hold_off && (stall_left == 0);
        end
    end

    // Reset, directed chains, random chains, then drain and report.
    initial
    begin
        int r;
        int len;
        logic pressure_done;
        sb = new();
        quiet_mode   = 1'b0;
        hold_request = 1'b0;
        items_sent   = 0;
        chains_sent  = 0;
        pressure_done = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        vec_x     = '0;
        vec_y     = '0;
        vec_z     = '0;
        chain_end = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single element chains at both extremes.
        send_vec(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
        send_vec(16'h8000, 16'h8000, 16'h8000, 1'b1);
        // Short chain of mixed extremes.
        send_vec(16'h7fff, 16'h8000, 16'h0000, 1'b0);
        send_vec(16'h8000, 16'h7fff, 16'hffff, 1'b0);
        send_vec(16'h0000, 16'h0001, 16'h7fff, 1'b1);
        // Chain shorter than the pipeline depth, alternating extremes.
        for (int i = 0; i < 18; i++)
        begin
            if (i % 2 == 0)
                send_vec(16'h7fff, 16'h8000, 16'h7fff, i == 17);
            else
                send_vec(16'h8000, 16'h7fff, 16'h8000, i == 17);
        end

        // Random chains of mixed length; one long chain meets the receiver hold-off.
        while (items_sent < TOTAL_ITEMS)
        begin
            if (!pressure_done && items_sent >= 100)
            begin
                quiet_mode   = 1'b1;
                hold_request <= 1'b1;
                send_chain(90);
                pressure_done = 1'b1;
            end
            else
            begin
                quiet_mode = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 40)
                    len = $urandom_range(1, 8);
                else if (r < 75)
                    len = $urandom_range(9, 30);
                else
                    len = $urandom_range(26, 60);
                // The last chain is cut so the run ends near the planned item count.
                if (len > TOTAL_ITEMS - items_sent)
                    len = TOTAL_ITEMS - items_sent;
                send_chain(len);
            end
        end
        quiet_mode = 1'b0;
        in_valid <= 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d vectors in %0d chains, checked %0d smoothed vectors in %0d cycles.",
                 items_sent, chains_sent, sb.checked, cycles);
        $display("Covered single and short chains, extremes, random gaps and a long output stall.");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
design/vcgs_pkg.sv
design/vcgs_lane.sv
design/vcgs_pass.sv
design/vector_chain_gaussian_smoother.sv
test/testbench.sv
